// ===== rtl/dri_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Delta rail IK package
// Shared widths, constants, register codes and bundle types for the linear
// delta inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package dri_pkg;

    localparam int FRAC_BITS_DEF   = 10;
    localparam int COORD_WIDTH_DEF = 23;

    localparam int IN_W       = 22;
    localparam int ROD_W      = 21;
    localparam int RAD_W      = 18;
    localparam int HOME_W     = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam int CW  = 24;
    localparam int PW  = 24;
    localparam int DW  = 46;
    localparam int RW  = DW / 2;
    localparam int QW  = 49;

    localparam int K_C3 = 56756;
    localparam int K_R2 = 46341;

    localparam logic signed [33:0] WXK [3] = '{34'sd0, 34'sd2630129796, -34'sd2630129796};
    localparam logic signed [33:0] WYK [3] = '{34'sd3037003776, -34'sd1518501888,
                                               -34'sd1518501888};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROD_LENGTH      = 3'd0,
        REG_EFFECTOR_RADIUS = 3'd1,
        REG_HOME_DIST_A     = 3'd2,
        REG_HOME_DIST_B     = 3'd3,
        REG_HOME_DIST_C     = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ZLIMIT = 2'd1,
        ST_NOSOL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [ROD_W-1:0]         rod;
        logic [2*ROD_W-1:0]       rod2;
        logic [RAD_W-1:0]         rad;
        logic [RAD_W-1:0]         sr;
        logic [RAD_W-1:0]         hr;
        logic [2:0][HOME_W-1:0]   home;
    } cfg_t;

    typedef struct packed {
        logic [2:0][PW-1:0] p;
        status_t            status;
    } side_t;

endpackage
`default_nettype wire

// ===== rtl/dri_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Delta rail IK configuration registers
// Holds the geometry registers and the values derived from them.
// ----------------------------------------------------------------------------
module dri_cfg #(
    parameter int FRAC_BITS = dri_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dri_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dri_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dri_pkg::cfg_t                        cfg
);
    import dri_pkg::*;

    localparam logic [63:0] ROD_RST64  = 64'd975 << FRAC_BITS;
    localparam logic [63:0] RAD_RST64  = 64'd50 << FRAC_BITS;
    localparam logic [63:0] HOME_RST64 = 64'd1110 << FRAC_BITS;
    localparam logic [ROD_W-1:0]  ROD_RST  = ROD_RST64[ROD_W-1:0];
    localparam logic [RAD_W-1:0]  RAD_RST  = RAD_RST64[RAD_W-1:0];
    localparam logic [HOME_W-1:0] HOME_RST = HOME_RST64[HOME_W-1:0];
    localparam logic [63:0] SR_RST64   = ((64'(RAD_RST) * 64'(K_C3)) + 64'd32768) >> 16;
    localparam logic [63:0] HR_RST64   = (64'(RAD_RST) + 64'd1) >> 1;
    localparam logic [63:0] ROD2_RST64 = 64'(ROD_RST) * 64'(ROD_RST);

    logic [ROD_W-1:0]       rod_reg, rod_next;
    logic [RAD_W-1:0]       rad_reg, rad_next;
    logic [2:0][HOME_W-1:0] home_reg, home_next;
    logic [RAD_W-1:0]       sr_reg, sr_next;
    logic [RAD_W-1:0]       hr_reg, hr_next;
    logic [2*ROD_W-1:0]     rod2_reg, rod2_next;
    logic [RAD_W+16:0]      sr_prod;
    logic [RAD_W:0]         hr_sum;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        rod_next  = rod_reg;
        rad_next  = rad_reg;
        home_next = home_reg;
        if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ROD_LENGTH:      rod_next    = cfg_data[ROD_W-1:0];
                REG_EFFECTOR_RADIUS: rad_next    = cfg_data[RAD_W-1:0];
                REG_HOME_DIST_A:     home_next[0] = cfg_data[HOME_W-1:0];
                REG_HOME_DIST_B:     home_next[1] = cfg_data[HOME_W-1:0];
                REG_HOME_DIST_C:     home_next[2] = cfg_data[HOME_W-1:0];
                default:             rod_next    = rod_reg;
            endcase
        end
    end

    always_comb
    begin
        sr_prod   = ({17'd0, rad_reg} * (RAD_W+17)'(K_C3)) + (RAD_W+17)'(32768);
        sr_next   = sr_prod[16 +: RAD_W];
        hr_sum    = {1'b0, rad_reg} + (RAD_W+1)'(1);
        hr_next   = hr_sum[RAD_W:1];
        rod2_next = {{ROD_W{1'b0}}, rod_reg} * {{ROD_W{1'b0}}, rod_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rod_reg  <= ROD_RST;
            rad_reg  <= RAD_RST;
            home_reg <= {HOME_RST, HOME_RST, HOME_RST};
            sr_reg   <= SR_RST64[RAD_W-1:0];
            hr_reg   <= HR_RST64[RAD_W-1:0];
            rod2_reg <= ROD2_RST64[2*ROD_W-1:0];
        end
        else
        begin
            rod_reg  <= rod_next;
            rad_reg  <= rad_next;
            home_reg <= home_next;
            sr_reg   <= sr_next;
            hr_reg   <= hr_next;
            rod2_reg <= rod2_next;
        end
    end

    always_comb
    begin
        cfg.rod  = rod_reg;
        cfg.rod2 = rod2_reg;
        cfg.rad  = rad_reg;
        cfg.sr   = sr_reg;
        cfg.hr   = hr_reg;
        cfg.home = home_reg;
    end

endmodule
`default_nettype wire

// ===== rtl/dri_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Delta rail IK front end
// Six stages: joint offsets, rail projection and the discriminant per rail.
// ----------------------------------------------------------------------------
module dri_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire dri_pkg::cfg_t                      cfg,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [dri_pkg::IN_W-1:0]    target_x,
    input  wire logic signed [dri_pkg::IN_W-1:0]    target_y,
    input  wire logic signed [dri_pkg::IN_W-1:0]    target_z,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [2:0][dri_pkg::DW-1:0]             out_rad,
    output dri_pkg::side_t                          out_side
);
    import dri_pkg::*;

    localparam int MW = 58;
    localparam int AW = 60;
    localparam int SW = 51;
    localparam logic signed [AW-1:0] HALF32 = AW'(64'sd1 <<< 31);

    logic [5:0] v_reg;
    logic [5:0] en;

    logic signed [IN_W-1:0] x1_reg, y1_reg, z1_reg;

    logic signed [CW-1:0]   px2_reg [3], px2_next [3];
    logic signed [CW-1:0]   py2_reg [3], py2_next [3];
    logic signed [IN_W-1:0] z2_reg;
    logic                   zf2_reg, zf2_next;

    logic signed [MW-1:0]   mx3_reg [3], mx3_next [3];
    logic signed [MW-1:0]   my3_reg [3], my3_next [3];
    logic signed [39:0]     mz3_reg, mz3_next;
    logic signed [47:0]     sx3_reg [3], sx3_next [3];
    logic signed [47:0]     sy3_reg [3], sy3_next [3];
    logic signed [43:0]     sz3_reg, sz3_next;
    logic                   zf3_reg;

    logic signed [AW-1:0]   acc [3];
    logic signed [PW-1:0]   p4_reg [3], p4_next [3];
    logic signed [QW-1:0]   q4_reg [3], q4_next [3];
    logic                   zf4_reg;

    logic signed [47:0]     pp5_reg [3], pp5_next [3];
    logic signed [PW-1:0]   p5_reg [3];
    logic signed [QW-1:0]   q5_reg [3];
    logic                   zf5_reg;

    logic signed [SW-1:0]   dd [3];
    logic [2:0]             neg;
    logic [DW-1:0]          rad6_reg [3], rad6_next [3];
    logic signed [PW-1:0]   p6_reg [3];
    status_t                status6_reg, status6_next;

    assign en[5] = !v_reg[5] || out_ready;
    for (genvar k = 0; k < 5; k++)
    begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end
    assign in_ready  = en[0];
    assign out_valid = v_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            for (int k = 1; k < 6; k++)
            begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_comb
    begin
        px2_next[0] = CW'(x1_reg);
        px2_next[1] = CW'(x1_reg) + $signed({6'd0, cfg.sr});
        px2_next[2] = CW'(x1_reg) - $signed({6'd0, cfg.sr});
        py2_next[0] = CW'(y1_reg) + $signed({6'd0, cfg.rad});
        py2_next[1] = CW'(y1_reg) - $signed({6'd0, cfg.hr});
        py2_next[2] = CW'(y1_reg) - $signed({6'd0, cfg.hr});
        zf2_next    = $signed({z1_reg[IN_W-1], z1_reg}) > $signed({2'b00, cfg.rod});
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mx3_next[i] = MW'(px2_reg[i]) * MW'(WXK[i]);
            my3_next[i] = MW'(py2_reg[i]) * MW'(WYK[i]);
            sx3_next[i] = 48'(px2_reg[i]) * 48'(px2_reg[i]);
            sy3_next[i] = 48'(py2_reg[i]) * 48'(py2_reg[i]);
        end
        mz3_next = 40'(z2_reg) * $signed(40'(K_R2));
        sz3_next = 44'(z2_reg) * 44'(z2_reg);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i]     = AW'(mx3_reg[i]) + AW'(my3_reg[i]) + (AW'(mz3_reg) <<< 16) + HALF32;
            p4_next[i] = acc[i][32 +: PW];
            q4_next[i] = QW'(sx3_reg[i]) + QW'(sy3_reg[i]) + QW'(sz3_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pp5_next[i] = 48'(p4_reg[i]) * 48'(p4_reg[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dd[i]        = SW'(pp5_reg[i]) - SW'(q5_reg[i])
                           + $signed({{(SW-2*ROD_W){1'b0}}, cfg.rod2});
            neg[i]       = dd[i][SW-1];
            rad6_next[i] = neg[i] ? '0 : dd[i][DW-1:0];
        end
        if (zf5_reg)
            status6_next = ST_ZLIMIT;
        else if (|neg)
            status6_next = ST_NOSOL;
        else
            status6_next = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x1_reg <= target_x;
            y1_reg <= target_y;
            z1_reg <= target_z;
        end
        if (en[1])
        begin
            px2_reg <= px2_next;
            py2_reg <= py2_next;
            z2_reg  <= z1_reg;
            zf2_reg <= zf2_next;
        end
        if (en[2])
        begin
            mx3_reg <= mx3_next;
            my3_reg <= my3_next;
            mz3_reg <= mz3_next;
            sx3_reg <= sx3_next;
            sy3_reg <= sy3_next;
            sz3_reg <= sz3_next;
            zf3_reg <= zf2_reg;
        end
        if (en[3])
        begin
            p4_reg  <= p4_next;
            q4_reg  <= q4_next;
            zf4_reg <= zf3_reg;
        end
        if (en[4])
        begin
            pp5_reg <= pp5_next;
            p5_reg  <= p4_reg;
            q5_reg  <= q4_reg;
            zf5_reg <= zf4_reg;
        end
        if (en[5])
        begin
            rad6_reg    <= rad6_next;
            p6_reg      <= p5_reg;
            status6_reg <= status6_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            out_rad[i]    = rad6_reg[i];
            out_side.p[i] = p6_reg[i];
        end
        out_side.status = status6_reg;
    end

endmodule
`default_nettype wire

// ===== rtl/dri_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Delta rail IK square root
// Pipelined digit-by-digit integer square root, one root bit per stage,
// three rails in lockstep.
// ----------------------------------------------------------------------------
module dri_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2:0][dri_pkg::DW-1:0]   in_rad,
    input  wire dri_pkg::side_t                in_side,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [2:0][dri_pkg::RW-1:0]        out_root,
    output dri_pkg::side_t                     out_side
);
    import dri_pkg::*;

    localparam int RMW = RW + 2;

    logic             v_reg    [RW];
    logic             en       [RW];
    logic [RMW-1:0]   rem_reg  [RW][3];
    logic [RW-1:0]    root_reg [RW][3];
    logic [DW-1:0]    rad_reg  [RW][3];
    side_t            side_reg [RW];

    for (genvar j = 0; j < RW; j++)
    begin : g_stage
        logic           vi;
        logic           en_nx;
        logic [RMW-1:0] rem_in   [3];
        logic [RW-1:0]  root_in  [3];
        logic [DW-1:0]  rad_in   [3];
        side_t          side_in;
        logic [RMW+1:0] remt     [3];
        logic [RMW+1:0] trial    [3];
        logic [RMW-1:0] rem_next [3];
        logic [RW-1:0]  root_next[3];

        if (j == 0)
        begin : g_first
            assign vi      = in_valid;
            assign side_in = in_side;
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign rem_in[l]  = '0;
                assign root_in[l] = '0;
                assign rad_in[l]  = in_rad[l];
            end
        end
        else
        begin : g_next
            assign vi      = v_reg[j-1];
            assign side_in = side_reg[j-1];
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign rem_in[l]  = rem_reg[j-1][l];
                assign root_in[l] = root_reg[j-1][l];
                assign rad_in[l]  = rad_reg[j-1][l];
            end
        end

        if (j == RW - 1)
        begin : g_last
            assign en_nx = out_ready;
        end
        else
        begin : g_mid
            assign en_nx = en[j+1];
        end

        assign en[j] = !v_reg[j] || en_nx;

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                remt[l]  = {rem_in[l], rad_in[l][DW-1-2*j -: 2]};
                trial[l] = (RMW+2)'({root_in[l], 2'b01});
                if (remt[l] >= trial[l])
                begin
                    rem_next[l]  = RMW'(remt[l] - trial[l]);
                    root_next[l] = {root_in[l][RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l]  = RMW'(remt[l]);
                    root_next[l] = {root_in[l][RW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en[j])
                v_reg[j] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                side_reg[j] <= side_in;
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[j][l]  <= rem_next[l];
                    root_reg[j][l] <= root_next[l];
                    rad_reg[j][l]  <= rad_in[l];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[RW-1];
    assign out_side  = side_reg[RW-1];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            out_root[l] = root_reg[RW-1][l];
        end
    end

    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[RW-1] && !out_ready |=> v_reg[RW-1])
        else $error("Square root output word lost while stalled.");

    a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[RW-1] |->
            ((DW+2)'(root_reg[RW-1][0]) * (DW+2)'(root_reg[RW-1][0])
                <= (DW+2)'(rad_reg[RW-1][0]))
            && ((DW+2)'(root_reg[RW-1][1]) * (DW+2)'(root_reg[RW-1][1])
                <= (DW+2)'(rad_reg[RW-1][1]))
            && ((DW+2)'(root_reg[RW-1][2]) * (DW+2)'(root_reg[RW-1][2])
                <= (DW+2)'(rad_reg[RW-1][2])))
        else $error("Square root is too large.");

    a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[RW-1] |->
            (((DW+2)'(root_reg[RW-1][0]) + (DW+2)'(1))
                * ((DW+2)'(root_reg[RW-1][0]) + (DW+2)'(1))
                > (DW+2)'(rad_reg[RW-1][0]))
            && (((DW+2)'(root_reg[RW-1][1]) + (DW+2)'(1))
                * ((DW+2)'(root_reg[RW-1][1]) + (DW+2)'(1))
                > (DW+2)'(rad_reg[RW-1][1]))
            && (((DW+2)'(root_reg[RW-1][2]) + (DW+2)'(1))
                * ((DW+2)'(root_reg[RW-1][2]) + (DW+2)'(1))
                > (DW+2)'(rad_reg[RW-1][2])))
        else $error("Square root is too small.");

endmodule
`default_nettype wire

// ===== rtl/dri_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Delta rail IK back end
// Forms the carriage distances from home, saturates them and holds the
// output word.
// ----------------------------------------------------------------------------
module dri_back #(
    parameter int COORD_WIDTH = dri_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dri_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2:0][dri_pkg::RW-1:0]   in_root,
    input  wire dri_pkg::side_t                in_side,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0]      pos_a,
    output logic signed [COORD_WIDTH-1:0]      pos_b,
    output logic signed [COORD_WIDTH-1:0]      pos_c,
    output logic [1:0]                         status
);
    import dri_pkg::*;

    localparam int VW = 27;
    localparam int EW = ((VW > COORD_WIDTH) ? VW : COORD_WIDTH) + 1;
    localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] SAT_LO = EW'(-(64'sd1 <<< (COORD_WIDTH - 1)));

    logic                          out_valid_reg;
    logic                          en;
    logic signed [EW-1:0]          val  [3];
    logic signed [EW-1:0]          satv [3];
    logic signed [COORD_WIDTH-1:0] pos_next [3];
    logic signed [COORD_WIDTH-1:0] pos_reg  [3];
    status_t                       status_reg;

    assign en        = !out_valid_reg || !out_stall;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            val[l] = EW'($signed({1'b0, cfg.home[l]})) - EW'($signed(in_side.p[l]))
                     - EW'($signed({1'b0, in_root[l]}));
            if (val[l] > SAT_HI)
                satv[l] = SAT_HI;
            else if (val[l] < SAT_LO)
                satv[l] = SAT_LO;
            else
                satv[l] = val[l];
            pos_next[l] = (in_side.status == ST_OK) ? satv[l][COORD_WIDTH-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg    <= pos_next;
            status_reg <= in_side.status;
        end
    end

    assign pos_a  = pos_reg[0];
    assign pos_b  = pos_reg[1];
    assign pos_c  = pos_reg[2];
    assign status = status_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> pos_a == '0 && pos_b == '0 && pos_c == '0)
        else $error("Error word carries nonzero positions.");

    a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && en |=> out_valid_reg)
        else $error("Accepted word did not reach the output register.");

    a_status_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && en |=> status_reg == $past(in_side.status))
        else $error("Status changed on its way to the output.");

endmodule
`default_nettype wire

// ===== rtl/delta_rail_inverse_kinematics_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Delta rail inverse kinematics top level
// A word accepted at the input passes six front stages, 23 square root stages
// and the output register before it shows on the output.
// Throughput is one word per cycle unless the output stalls; the pipeline
// is fully stalled only when every stage holds a word and the output stalls.
// Reset loads the default geometry and empties the pipeline; no clearing pass.
// ----------------------------------------------------------------------------
module delta_rail_inverse_kinematics_top #(
    parameter int FRAC_BITS   = dri_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = dri_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dri_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dri_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [dri_pkg::IN_W-1:0]   target_x,
    input  wire logic signed [dri_pkg::IN_W-1:0]   target_y,
    input  wire logic signed [dri_pkg::IN_W-1:0]   target_z,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [COORD_WIDTH-1:0]          pos_a,
    output logic signed [COORD_WIDTH-1:0]          pos_b,
    output logic signed [COORD_WIDTH-1:0]          pos_c,
    output logic [1:0]                             status
);
    import dri_pkg::*;

    cfg_t                cfg;
    logic                front_ready;
    logic                front_valid;
    logic [2:0][DW-1:0]  front_rad;
    side_t               front_side;
    logic                sqrt_ready;
    logic                sqrt_valid;
    logic [2:0][RW-1:0]  sqrt_root;
    side_t               sqrt_side;
    logic                back_ready;

    dri_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dri_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (front_ready),
        .target_x  (target_x),
        .target_y  (target_y),
        .target_z  (target_z),
        .out_valid (front_valid),
        .out_ready (sqrt_ready),
        .out_rad   (front_rad),
        .out_side  (front_side)
    );

    dri_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (sqrt_ready),
        .in_rad    (front_rad),
        .in_side   (front_side),
        .out_valid (sqrt_valid),
        .out_ready (back_ready),
        .out_root  (sqrt_root),
        .out_side  (sqrt_side)
    );

    dri_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (sqrt_valid),
        .in_ready  (back_ready),
        .in_root   (sqrt_root),
        .in_side   (sqrt_side),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pos_a     (pos_a),
        .pos_b     (pos_b),
        .pos_c     (pos_c),
        .status    (status)
    );

    assign in_stall = !front_ready;

endmodule
`default_nettype wire
